@@ rtl/srfw_pkg.sv @@
// shared types, constants and helpers for the scale reply weight parser
// no dependencies; imported by every rtl module of the block
`default_nettype none

package srfw_pkg;

    localparam logic [7:0] BYTE_OPEN   = 8'hFF;
    localparam logic [7:0] BYTE_ESCAPE = 8'hFE;

    localparam logic [2:0] POS_BCD_LO = 3'd3;
    localparam logic [2:0] POS_BCD_HI = 3'd5;
    localparam logic [2:0] POS_STATUS = 3'd6;

    localparam int STAT_NEG      = 7;
    localparam int STAT_STABLE   = 4;
    localparam int STAT_OVERLOAD = 3;

    localparam logic [2:0] POINT_MAX = 3'd3;

    localparam int MAG_W   = 21;
    localparam int SCALE_W = 10;
    localparam int PROD_W  = 31;

    localparam logic signed [31:0] WEIGHT_LIMIT = 32'sd1666665000;

    // one frame worth of work for the back end
    typedef struct packed {
        logic [23:0] bcd;
        logic [7:0]  status;
    } t_job;

    // packed bcd byte weighted at face value: high*10 + low, at most 165
    function automatic logic [7:0] bcd_pair(input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'd0, b[7:4]};
        lo = {4'd0, b[3:0]};
        return 8'((hi << 3) + (hi << 1) + lo);
    endfunction

endpackage

`default_nettype wire

@@ rtl/scale_reply_frame_weight_parser_top.sv @@
// top level of the scale reply weight parser
// depends on srfw_pkg, srfw_front, srfw_queue and srfw_back
`default_nettype none

// Takes reply bytes from a scale link, one per transfer, and gives one weight
// result for every complete frame. An unescaped 0xFF (one not right after
// 0xFE) opens a frame; frame bytes 3..5 hold the weight as packed bcd, low byte
// first, and byte 6 is the status byte that closes the frame and yields the
// result: weight in grams scaled by 10^(3-pos) from status bits 2..0, negated
// when bit 7 is set, plus the stable (bit 4) and overload (bit 3) flags. A
// point position above 3 sets point_error and leaves the value unscaled.
// Nibbles above 9 are weighted at face value. tuser on the input marks the
// first byte of a new receive buffer, which clears all frame state first.
// Rate: one byte per clock while the job queue has room. A status byte's job
// passes through the job queue, back end stage a and the output register
// before its result reaches the output; the job queue (DEPTH entries) between
// the framing front end and the two-stage arithmetic back end absorbs output
// stalls, and input ready drops only while that queue is full.
module scale_reply_frame_weight_parser_top #(
    parameter int DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input byte stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  wire  [0:0]  i_s_tuser,   // [0] buffer_start
    // weight result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] weight_grams (signed)
    output logic [2:0]  o_m_tuser    // [0] stable, [1] overload, [2] point_error
);
    import srfw_pkg::*;

    // front end to queue
    logic  push;
    t_job  push_job;
    logic  q_ready;

    // queue to back end
    logic  q_valid;
    t_job  q_job;
    logic  pop;

    // back end results
    logic signed [31:0] weight;
    logic               stable;
    logic               overload;
    logic               point_error;

    // framing, escape tracking and bcd capture; one job per status byte
    srfw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_byte    (i_s_tdata),
        .i_start   (i_s_tuser[0]),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (push_job)
    );

    // decouples byte intake from result delivery
    srfw_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // bcd conversion, point scaling, sign and the output register
    srfw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (q_job),
        .o_pop         (pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_weight      (weight),
        .o_stable      (stable),
        .o_overload    (overload),
        .o_point_error (point_error)
    );

    assign o_m_tdata = weight;
    assign o_m_tuser = {point_error, overload, stable};

endmodule

`default_nettype wire

@@ rtl/srfw_front.sv @@
// front end: byte framing, escape tracking and bcd capture
// depends on srfw_pkg; pushes one job per status byte into srfw_queue
`default_nettype none

module srfw_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_byte,
    input  wire                 i_start,
    input  wire                 i_q_ready,
    output logic                o_push,
    output srfw_pkg::t_job      o_job
);
    import srfw_pkg::*;

    logic        r_esc,  n_esc;
    logic        r_inf,  n_inf;
    logic [2:0]  r_pos,  n_pos;
    logic [23:0] r_bcd,  n_bcd;

    logic        e_esc;
    logic        e_inf;
    logic [2:0]  e_pos;
    logic [23:0] e_bcd;
    logic [2:0]  pos_inc;
    logic        accept;
    logic        is_status;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && o_ready;

    // a buffer start clears frame state before this byte is looked at
    assign e_esc   = i_start ? 1'b0  : r_esc;
    assign e_inf   = i_start ? 1'b0  : r_inf;
    assign e_pos   = i_start ? 3'd0  : r_pos;
    assign e_bcd   = i_start ? 24'd0 : r_bcd;
    assign pos_inc = e_pos + 3'd1;

    always_comb begin
        n_esc     = i_byte == BYTE_ESCAPE;
        n_inf     = e_inf;
        n_pos     = e_pos;
        n_bcd     = e_bcd;
        is_status = 1'b0;
        if (i_byte == BYTE_OPEN && !e_esc) begin
            n_inf = 1'b1;
            n_pos = 3'd0;
            n_bcd = 24'd0;
        end else if (e_inf) begin
            n_pos = pos_inc;
            if (pos_inc >= POS_BCD_LO && pos_inc <= POS_BCD_HI) begin
                case (pos_inc)
                    POS_BCD_LO:        n_bcd[7:0]   = i_byte;
                    POS_BCD_LO + 3'd1: n_bcd[15:8]  = i_byte;
                    default:           n_bcd[23:16] = i_byte;
                endcase
            end else if (pos_inc == POS_STATUS) begin
                is_status = 1'b1;
                n_inf     = 1'b0;
                n_pos     = 3'd0;
            end
        end
    end

    assign o_push       = accept && is_status;
    assign o_job.bcd    = e_bcd;
    assign o_job.status = i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_inf <= 1'b0;
            r_pos <= 3'd0;
            r_bcd <= 24'd0;
        end else if (accept) begin
            r_esc <= n_esc;
            r_inf <= n_inf;
            r_pos <= n_pos;
            r_bcd <= n_bcd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/srfw_queue.sv @@
// small register fifo carrying frame jobs from front end to back end
// depends on srfw_pkg for the job type
`default_nettype none

module srfw_queue #(
    parameter int DEPTH = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  srfw_pkg::t_job      i_job,
    output logic                o_ready,
    input  wire                 i_pop,
    output logic                o_valid,
    output srfw_pkg::t_job      o_job
);
    import srfw_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [IW-1:0] r_wr, n_wr;
    logic [IW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_ready = r_cnt != FULL;
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + IW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + IW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL)
        else $error("queue count above depth");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_cnt == $past(r_cnt) + CW'(1))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == FULL) |-> r_wr == r_rd)
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ rtl/srfw_back.sv @@
// back end: bcd to binary, point scaling, sign and output register
// depends on srfw_pkg; pops jobs from srfw_queue
`default_nettype none

module srfw_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  srfw_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic signed [31:0]  o_weight,
    output logic                o_stable,
    output logic                o_overload,
    output logic                o_point_error
);
    import srfw_pkg::*;

    // stage a: magnitude and status
    logic               r_a_valid;
    logic [MAG_W-1:0]   r_a_mag;
    logic [7:0]         r_a_status;
    logic [MAG_W-1:0]   n_a_mag;

    // stage b: output register
    logic               r_b_valid;
    logic signed [31:0] r_b_weight;
    logic               r_b_stable;
    logic               r_b_overload;
    logic               r_b_perr;

    logic               b_free;
    logic               a_adv;
    logic               a_free;
    logic [SCALE_W-1:0] scale;
    logic               perr;
    logic [PROD_W-1:0]  prod;
    logic [31:0]        n_b_weight;

    assign b_free = !r_b_valid || i_ready;
    assign a_adv  = r_a_valid && b_free;
    assign a_free = !r_a_valid || a_adv;
    assign o_pop  = i_q_valid && a_free;

    assign n_a_mag = MAG_W'(bcd_pair(i_job.bcd[7:0]))
                   + MAG_W'(bcd_pair(i_job.bcd[15:8])) * MAG_W'(100)
                   + MAG_W'(bcd_pair(i_job.bcd[23:16])) * MAG_W'(10000);

    always_comb begin
        perr = 1'b0;
        unique case (r_a_status[2:0])
            3'd0:    scale = SCALE_W'(1000);
            3'd1:    scale = SCALE_W'(100);
            3'd2:    scale = SCALE_W'(10);
            3'd3:    scale = SCALE_W'(1);
            default: begin
                scale = SCALE_W'(1);
                perr  = 1'b1;
            end
        endcase
    end

    assign prod       = PROD_W'(r_a_mag) * PROD_W'(scale);
    assign n_b_weight = r_a_status[STAT_NEG] ? -{1'b0, prod} : {1'b0, prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_mag    <= n_a_mag;
            r_a_status <= i_job.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_weight   <= n_b_weight;
            r_b_stable   <= r_a_status[STAT_STABLE];
            r_b_overload <= r_a_status[STAT_OVERLOAD];
            r_b_perr     <= perr;
        end
    end

    assign o_valid       = r_b_valid;
    assign o_weight      = r_b_weight;
    assign o_stable      = r_b_stable;
    assign o_overload    = r_b_overload;
    assign o_point_error = r_b_perr;

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_weight <= WEIGHT_LIMIT && r_b_weight >= -WEIGHT_LIMIT))
        else $error("weight outside reachable range");

    a_perr_unscaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_perr) |->
            (r_b_weight <= 32'sd1666665 && r_b_weight >= -32'sd1666665))
        else $error("point error result was scaled");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_adv) |=> (r_a_valid && $stable(r_a_mag) && $stable(r_a_status)))
        else $error("stalled stage a lost its job");

endmodule

`default_nettype wire
